FILE: design/tcce_pkg.sv
// ----------------------------------------------------------------------------
// tcce_pkg: shared types and constants of the text console engine
// Opcodes, control characters, register indexes and the address request.
// ----------------------------------------------------------------------------
package tcce_pkg;

  // widest row and column fields the engine supports
  localparam int unsigned ROW_W = 6;
  localparam int unsigned COL_W = 7;

  // opcodes
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  // control characters
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int unsigned TAB_STEP = 4;

  localparam logic [15:0] RESET_CELL = 16'h0720;

  // configuration register indexes
  localparam logic REG_SCROLL_ATTR = 1'b0;
  localparam logic REG_LOG_EN      = 1'b1;

  localparam logic [7:0] SCROLL_ATTR_RST = 8'h07;

  // request to the shared address unit
  typedef struct packed {
    logic             start;
    logic             ring;   // 1: row is logical, add top-row offset
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } addr_req_t;

endpackage

FILE: design/tcce_addr_unit.sv
// ----------------------------------------------------------------------------
// tcce_addr_unit: shared cell address unit
// Registers (ring ? (top + row) mod ROWS : row) * COLS + col on each start.
// ----------------------------------------------------------------------------
module tcce_addr_unit
  import tcce_pkg::*;
#(
  parameter int unsigned ROWS = 25,
  parameter int unsigned COLS = 80,
  parameter int unsigned AW   = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  addr_req_t        req_i,
  input  logic [ROW_W-1:0] top_i,
  output logic [AW-1:0]    addr_o
);

  localparam logic [ROW_W:0] ROWS_C = (ROW_W + 1)'(ROWS);

  logic [ROW_W:0]   sum;
  logic [ROW_W-1:0] phys;
  logic [AW-1:0]    addr_d;
  logic [AW-1:0]    addr_q;

  always_comb begin
    sum = {1'b0, top_i} + {1'b0, req_i.row};
    if (!req_i.ring) begin
      phys = req_i.row;
    end else if (sum >= ROWS_C) begin
      phys = ROW_W'(sum - ROWS_C);
    end else begin
      phys = ROW_W'(sum);
    end
    addr_d = AW'(phys * AW'(COLS)) + AW'(req_i.col);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
    end else if (req_i.start) begin
      addr_q <= addr_d;
    end
  end

  assign addr_o = addr_q;

endmodule

FILE: design/tcce_cell_mem.sv
// ----------------------------------------------------------------------------
// tcce_cell_mem: cell store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tcce_cell_mem
  import tcce_pkg::*;
#(
  parameter int unsigned DEPTH = 2000,
  parameter int unsigned AW    = 11
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [15:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [15:0]   rdata_o
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/text_console_char_engine.sv
// ----------------------------------------------------------------------------
// text_console_char_engine: text-mode console character engine
// Cell store, cursor and scroll handling for a character console.
// ----------------------------------------------------------------------------
// Input words arrive on s_axis; each gives exactly one result word on m_axis.
// Opcodes: put character, read cell, flush cursor, no-op.
// Registers are written on the cfg channel (index 0 scroll blank attribute,
// index 1 log enable); cfg_ready_o is always high, write only while idle.
// One item at a time, sequenced around a single address unit (multiply-add)
// and a single-port-write cell memory:
//   put: decode, cell write when it writes a cell, location, result
//   put with scroll: scroll base step, then one blank cell per cycle
//   read: decode, cell read (skipped when out of range), location, result
//   flush / no-op: decode, location, result; next word taken back in idle
// The result sits in an output register; the engine takes the next word
// while it waits, and holds the following result until the slot is free.
// After reset the store is swept to space/attribute 07 over all ROWS*COLS cells
// (2000 by default), with s_axis_tready low; cfg writes are taken meanwhile.
// ----------------------------------------------------------------------------
module text_console_char_engine
  import tcce_pkg::*;
#(
  parameter int unsigned ROWS = 25,
  parameter int unsigned COLS = 80
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // opcode[1:0], character[9:2], attribute[17:10], defer_cursor[18],
  // read_row[23:19], read_col[30:24]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  // cursor_row[4:0], cursor_col[11:5], cursor_location[22:12],
  // cursor_update[23], scrolled[24], log_valid[25], log_byte[33:26],
  // read_data[49:34]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  localparam int unsigned DEPTH = ROWS * COLS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned CW    = $clog2(COLS);
  localparam int unsigned RX    = RW + 1;
  localparam int unsigned CX    = CW + 1;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_WRITE,
    S_SCR_BASE,
    S_SCROLL,
    S_RD_MEM,
    S_LOC,
    S_EMIT
  } state_e;

  state_e       state_q;
  logic [AW-1:0] sweep_q;

  logic [1:0]   op_q;
  logic [7:0]   ch_q;
  logic [7:0]   attr_q;
  logic         defer_q;
  logic [4:0]   rrow_q;
  logic [6:0]   rcol_q;

  logic [RW-1:0] row_q;
  logic [CW-1:0] col_q;
  logic [RW-1:0] top_q;
  logic          scr_q;
  logic          upd_q;
  logic [15:0]   wdat_q;
  logic [15:0]   rd_q;
  logic          in_range_q;

  logic [7:0]    scroll_attr_q;
  logic          log_en_q;

  logic          m_valid_q;
  logic [55:0]   m_data_q;

  // decode of a put
  logic [RX-1:0] row_x;
  logic [CX-1:0] col_x;
  logic [CW-1:0] wcol;
  logic [15:0]   wdat;
  logic          wr;
  logic          moved;
  logic          scr;
  logic          in_range;

  addr_req_t     req;
  logic [AW-1:0] unit_addr;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic          mem_re;
  logic [15:0]   mem_rdata;

  logic          out_free;
  logic [10:0]   loc;

  assign in_range = ({2'b00, rrow_q} < 7'(ROWS)) && ({1'b0, rcol_q} < 8'(COLS));

  always_comb begin
    row_x = {1'b0, row_q};
    col_x = {1'b0, col_q};
    wcol  = col_q;
    wdat  = {attr_q, ch_q};
    wr    = 1'b0;
    moved = 1'b1;
    scr   = 1'b0;
    case (ch_q)
      CH_BS: begin
        if (col_q != '0) begin
          wr    = 1'b1;
          wcol  = col_q - CW'(1);
          wdat  = {attr_q, CH_SPACE};
          col_x = col_x - CX'(1);
        end else begin
          moved = 1'b0;
        end
      end
      CH_CR: begin
        col_x = '0;
      end
      CH_LF: begin
        row_x = row_x + RX'(1);
        col_x = '0;
      end
      CH_TAB: begin
        col_x = (col_x + CX'(TAB_STEP)) & ~CX'(TAB_STEP - 1);
      end
      default: begin
        if (ch_q >= CH_SPACE) begin
          wr    = 1'b1;
          col_x = col_x + CX'(1);
        end else begin
          moved = 1'b0;
        end
      end
    endcase
    if (col_x >= CX'(COLS)) begin
      row_x = row_x + RX'(1);
      col_x = '0;
      moved = 1'b1;
    end
    if (row_x >= RX'(ROWS)) begin
      row_x = RX'(ROWS - 1);
      scr   = 1'b1;
      moved = 1'b1;
    end
  end

  // address unit requests
  always_comb begin
    req = '0;
    case (state_q)
      S_DECODE: begin
        req.start = 1'b1;
        req.ring  = 1'b1;
        if (op_q == OP_READ) begin
          req.row = ROW_W'(rrow_q);
          req.col = COL_W'(rcol_q);
        end else begin
          req.row = ROW_W'(row_q);
          req.col = COL_W'(wcol);
        end
      end
      S_SCR_BASE: begin
        req.start = 1'b1;
        req.ring  = 1'b1;
      end
      S_LOC: begin
        req.start = 1'b1;
        req.row   = ROW_W'(row_q);
        req.col   = COL_W'(col_q);
      end
      default: begin
        req = '0;
      end
    endcase
  end

  tcce_addr_unit #(
    .ROWS (ROWS),
    .COLS (COLS),
    .AW   (AW)
  ) u_addr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .top_i  (ROW_W'(top_q)),
    .addr_o (unit_addr)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = unit_addr;
    mem_wdata = wdat_q;
    case (state_q)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        mem_wdata = RESET_CELL;
      end
      S_WRITE: begin
        mem_we = 1'b1;
      end
      S_SCROLL: begin
        mem_we    = 1'b1;
        mem_waddr = unit_addr + sweep_q;
        mem_wdata = {scroll_attr_q, CH_SPACE};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign mem_re = (state_q == S_RD_MEM);

  tcce_cell_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (unit_addr),
    .rdata_o (mem_rdata)
  );

  assign out_free      = !m_valid_q || m_axis_tready;
  assign loc           = 11'(unit_addr);
  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_INIT;
      sweep_q       <= '0;
      row_q         <= '0;
      col_q         <= '0;
      top_q         <= '0;
      scroll_attr_q <= SCROLL_ATTR_RST;
      log_en_q      <= 1'b1;
      m_valid_q     <= 1'b0;
      m_data_q      <= '0;
      op_q          <= OP_NOP;
      ch_q          <= '0;
      attr_q        <= '0;
      defer_q       <= 1'b0;
      rrow_q        <= '0;
      rcol_q        <= '0;
      scr_q         <= 1'b0;
      upd_q         <= 1'b0;
      wdat_q        <= '0;
      rd_q          <= '0;
      in_range_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_SCROLL_ATTR: scroll_attr_q <= cfg_data_i;
          REG_LOG_EN:      log_en_q      <= cfg_data_i[0];
          default:         log_en_q      <= log_en_q;
        endcase
      end
      if (state_q == S_EMIT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_INIT: begin
          if (sweep_q == AW'(DEPTH - 1)) begin
            sweep_q <= '0;
            state_q <= S_IDLE;
          end else begin
            sweep_q <= sweep_q + AW'(1);
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op_q    <= s_axis_tdata[1:0];
            ch_q    <= s_axis_tdata[9:2];
            attr_q  <= s_axis_tdata[17:10];
            defer_q <= s_axis_tdata[18];
            rrow_q  <= s_axis_tdata[23:19];
            rcol_q  <= s_axis_tdata[30:24];
            state_q <= S_DECODE;
          end
        end
        S_DECODE: begin
          rd_q       <= '0;
          in_range_q <= in_range;
          if (op_q == OP_PUT) begin
            row_q  <= row_x[RW-1:0];
            col_q  <= col_x[CW-1:0];
            scr_q  <= scr;
            upd_q  <= moved && !defer_q;
            wdat_q <= wdat;
            if (wr) begin
              state_q <= S_WRITE;
            end else if (scr) begin
              state_q <= S_SCR_BASE;
            end else begin
              state_q <= S_LOC;
            end
          end else begin
            scr_q <= 1'b0;
            upd_q <= (op_q == OP_FLUSH);
            if (op_q == OP_READ && in_range) begin
              state_q <= S_RD_MEM;
            end else begin
              state_q <= S_LOC;
            end
          end
        end
        S_WRITE: begin
          state_q <= scr_q ? S_SCR_BASE : S_LOC;
        end
        S_SCR_BASE: begin
          sweep_q <= '0;
          state_q <= S_SCROLL;
        end
        S_SCROLL: begin
          if (sweep_q == AW'(COLS - 1)) begin
            sweep_q <= '0;
            top_q   <= (top_q == RW'(ROWS - 1)) ? '0 : top_q + RW'(1);
            state_q <= S_LOC;
          end else begin
            sweep_q <= sweep_q + AW'(1);
          end
        end
        S_RD_MEM: begin
          state_q <= S_LOC;
        end
        S_LOC: begin
          if (op_q == OP_READ && in_range_q) begin
            rd_q <= mem_rdata;
          end
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            m_data_q  <= {6'd0,
                          rd_q,
                          (op_q == OP_PUT && log_en_q) ? ch_q : 8'd0,
                          (op_q == OP_PUT && log_en_q),
                          scr_q,
                          upd_q,
                          loc,
                          7'(col_q),
                          5'(row_q)};
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, row_q} < RX'(ROWS))
    else $error("cursor row out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, col_q} < CX'(COLS))
    else $error("cursor column out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, top_q} < RX'(ROWS))
    else $error("top row offset out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !mem_we)
    else $error("cell store written while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCROLL && sweep_q == AW'(COLS - 1)) |=> top_q != $past(top_q))
    else $error("scroll did not advance top row offset");

endmodule

FILE: tb/text_console_char_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_engine_tb: self-checking bench for the console engine
// Drives put/read/flush/no-op words through the input stream and compares
// every result word field by field against an in-bench console model
// (cell store, ring offset, cursor). A directed table covers cursor and
// store corner cases, then randomized phases run under several register
// settings with random stalls, a long output hold-off and a drain pause.
// ----------------------------------------------------------------------------
module text_console_char_engine_tb;
  import tcce_pkg::*;

  localparam int unsigned ROWS          = 25;
  localparam int unsigned COLS          = 80;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES   = 2 * COLS;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned PHASE_WORDS   = 277;

  typedef struct packed {
    logic [4:0]  row;
    logic [6:0]  col;
    logic [10:0] loc;
    logic        upd;
    logic        scr;
    logic        lv;
    logic [7:0]  lb;
    logic [15:0] rd;
  } console_result_t;

  typedef struct packed {
    logic            known;
    console_result_t res;
  } pinned_t;

  typedef struct packed {
    logic [1:0]      op;
    logic [7:0]      ch;
    logic [7:0]      attr;
    logic            defer;
    logic [4:0]      rrow;
    logic [6:0]      rcol;
    logic [7:0]      rep;
    logic            known;
    console_result_t res;
  } plan_row_t;

  localparam plan_row_t DIRECTED [27] = '{
    '{OP_READ, 8'h00, 8'h00, 1'b0, 5'd0, 7'd0, 8'd1, 1'b1,
      '{5'd0, 7'd0, 11'd0, 1'b0, 1'b0, 1'b0, 8'h00, 16'h0720}},
    // out-of-range read
    '{OP_READ, 8'h00, 8'h00, 1'b0, 5'd31, 7'd127, 8'd1, 1'b1,
      '{5'd0, 7'd0, 11'd0, 1'b0, 1'b0, 1'b0, 8'h00, 16'h0000}},
    '{OP_READ, 8'h00, 8'h00, 1'b0, 5'd24, 7'd79, 8'd1, 1'b1,
      '{5'd0, 7'd0, 11'd0, 1'b0, 1'b0, 1'b0, 8'h00, 16'h0720}},
    '{OP_FLUSH, 8'h00, 8'h00, 1'b0, 5'd0, 7'd0, 8'd1, 1'b1,
      '{5'd0, 7'd0, 11'd0, 1'b1, 1'b0, 1'b0, 8'h00, 16'h0000}},
    '{OP_NOP, 8'hff, 8'hff, 1'b1, 5'd31, 7'd127, 8'd1, 1'b1,
      '{5'd0, 7'd0, 11'd0, 1'b0, 1'b0, 1'b0, 8'h00, 16'h0000}},
    // backspace at column 0, then a non-printing control code
    '{OP_PUT, CH_BS, 8'h11, 1'b0, 5'd0, 7'd0, 8'd1, 1'b1,
      '{5'd0, 7'd0, 11'd0, 1'b0, 1'b0, 1'b1, CH_BS, 16'h0000}},
    '{OP_PUT, 8'h1b, 8'h22, 1'b0, 5'd0, 7'd0, 8'd1, 1'b1,
      '{5'd0, 7'd0, 11'd0, 1'b0, 1'b0, 1'b1, 8'h1b, 16'h0000}},
    '{OP_PUT, 8'h41, 8'h1f, 1'b0, 5'd0, 7'd0, 8'd1, 1'b1,
      '{5'd0, 7'd1, 11'd1, 1'b1, 1'b0, 1'b1, 8'h41, 16'h0000}},
    '{OP_PUT, 8'hff, 8'hff, 1'b1, 5'd0, 7'd0, 8'd1, 1'b1,
      '{5'd0, 7'd2, 11'd2, 1'b0, 1'b0, 1'b1, 8'hff, 16'h0000}},
    '{OP_PUT, CH_BS, 8'h00, 1'b0, 5'd0, 7'd0, 8'd1, 1'b1,
      '{5'd0, 7'd1, 11'd1, 1'b1, 1'b0, 1'b1, CH_BS, 16'h0000}},
    '{OP_READ, 8'h00, 8'h00, 1'b0, 5'd0, 7'd1, 8'd1, 1'b1,
      '{5'd0, 7'd1, 11'd1, 1'b0, 1'b0, 1'b0, 8'h00, 16'h0020}},
    '{OP_PUT, CH_TAB, 8'h00, 1'b0, 5'd0, 7'd0, 8'd1, 1'b1,
      '{5'd0, 7'd4, 11'd4, 1'b1, 1'b0, 1'b1, CH_TAB, 16'h0000}},
    '{OP_PUT, CH_TAB, 8'h00, 1'b1, 5'd0, 7'd0, 8'd1, 1'b1,
      '{5'd0, 7'd8, 11'd8, 1'b0, 1'b0, 1'b1, CH_TAB, 16'h0000}},
    '{OP_PUT, CH_CR, 8'h00, 1'b0, 5'd0, 7'd0, 8'd1, 1'b1,
      '{5'd0, 7'd0, 11'd0, 1'b1, 1'b0, 1'b1, CH_CR, 16'h0000}},
    '{OP_PUT, CH_LF, 8'h00, 1'b0, 5'd0, 7'd0, 8'd1, 1'b1,
      '{5'd1, 7'd0, 11'd80, 1'b1, 1'b0, 1'b1, CH_LF, 16'h0000}},
    '{OP_READ, 8'h00, 8'h00, 1'b0, 5'd0, 7'd0, 8'd1, 1'b1,
      '{5'd1, 7'd0, 11'd80, 1'b0, 1'b0, 1'b0, 8'h00, 16'h1f41}},
    // tab runs off the row end, printable runs off the row end
    '{OP_PUT, CH_TAB, 8'h00, 1'b0, 5'd0, 7'd0, 8'd20, 1'b0, '0},
    '{OP_PUT, 8'h78, 8'h2e, 1'b0, 5'd0, 7'd0, 8'd80, 1'b0, '0},
    // walk to the last row, then scroll on newline
    '{OP_PUT, CH_LF, 8'h00, 1'b0, 5'd0, 7'd0, 8'd21, 1'b0, '0},
    '{OP_PUT, 8'h5a, 8'h5a, 1'b0, 5'd0, 7'd0, 8'd1, 1'b0, '0},
    '{OP_PUT, CH_LF, 8'h00, 1'b0, 5'd0, 7'd0, 8'd1, 1'b0, '0},
    '{OP_READ, 8'h00, 8'h00, 1'b0, 5'd24, 7'd0, 8'd1, 1'b0, '0},
    '{OP_READ, 8'h00, 8'h00, 1'b0, 5'd23, 7'd0, 8'd1, 1'b0, '0},
    // printable wrap on the last row scrolls, deferred
    '{OP_PUT, CH_TAB, 8'h00, 1'b0, 5'd0, 7'd0, 8'd19, 1'b0, '0},
    '{OP_PUT, 8'h71, 8'hc3, 1'b1, 5'd0, 7'd0, 8'd4, 1'b0, '0},
    '{OP_READ, 8'h00, 8'h00, 1'b0, 5'd0, 7'd0, 8'd1, 1'b0, '0},
    '{OP_READ, 8'h00, 8'h00, 1'b0, 5'd23, 7'd79, 8'd1, 1'b0, '0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [7:0]  cfg_data_i;

  // console model state
  logic [15:0] cells [ROWS*COLS];
  int unsigned top_row;
  int unsigned cur_row;
  int unsigned cur_col;
  logic [7:0]  blank_attr;
  logic        log_on;

  console_result_t pending_results [$];
  pinned_t         pinned_q [$];
  int unsigned     mismatches;

  bit rx_calm;
  bit tx_calm;
  bit hold_off;

  text_console_char_engine #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #30_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int unsigned cell_addr(int unsigned row, int unsigned col);
    return ((top_row + row) % ROWS) * COLS + col;
  endfunction

  function automatic console_result_t console_step(logic [31:0] w);
    console_result_t r;
    logic [1:0]  op;
    logic [7:0]  ch;
    logic [7:0]  attr;
    logic        defer;
    int unsigned rrow, rcol, row, col, base, c;
    bit          moved;
    op    = w[1:0];
    ch    = w[9:2];
    attr  = w[17:10];
    defer = w[18];
    rrow  = 32'(w[23:19]);
    rcol  = 32'(w[30:24]);
    r     = '0;
    row   = cur_row;
    col   = cur_col;
    moved = 1'b1;
    case (op)
      OP_PUT: begin
        if (ch == CH_BS) begin
          if (col > 0) begin
            cells[cell_addr(row, col - 1)] = {attr, CH_SPACE};
            col = col - 1;
          end else begin
            moved = 1'b0;
          end
        end else if (ch == CH_CR) begin
          col = 0;
        end else if (ch == CH_LF) begin
          row = row + 1;
          col = 0;
        end else if (ch == CH_TAB) begin
          col = (col / TAB_STEP + 1) * TAB_STEP;
        end else if (ch >= CH_SPACE) begin
          cells[cell_addr(row, col)] = {attr, ch};
          col = col + 1;
        end else begin
          moved = 1'b0;
        end
        if (col >= COLS) begin
          row   = row + 1;
          col   = 0;
          moved = 1'b1;
        end
        if (row >= ROWS) begin
          base = top_row * COLS;
          for (c = 0; c < COLS; c++) cells[base + c] = {blank_attr, CH_SPACE};
          top_row = (top_row + 1) % ROWS;
          row     = ROWS - 1;
          r.scr   = 1'b1;
          moved   = 1'b1;
        end
        cur_row = row;
        cur_col = col;
        r.upd   = moved && !defer;
        if (log_on) begin
          r.lv = 1'b1;
          r.lb = ch;
        end
      end
      OP_READ: begin
        if (rrow < ROWS && rcol < COLS) r.rd = cells[cell_addr(rrow, rcol)];
      end
      OP_FLUSH: r.upd = 1'b1;
      default: ;
    endcase
    r.row = 5'(cur_row);
    r.col = 7'(cur_col);
    r.loc = 11'(cur_row * COLS + cur_col);
    return r;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // input and output word tracking, sampled at the rising edge
  always @(posedge clk_i) begin : monitor
    console_result_t want;
    console_result_t got;
    pinned_t         pin;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      want = console_step(s_axis_tdata);
      pin  = pinned_q.pop_front();
      if (pin.known) want = pin.res;
      pending_results.push_back(want);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.row = m_axis_tdata[4:0];
      got.col = m_axis_tdata[11:5];
      got.loc = m_axis_tdata[22:12];
      got.upd = m_axis_tdata[23];
      got.scr = m_axis_tdata[24];
      got.lv  = m_axis_tdata[25];
      got.lb  = m_axis_tdata[33:26];
      got.rd  = m_axis_tdata[49:34];
      if (pending_results.size() == 0) begin
        $error("result word with nothing pending");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("cursor_row", want.row, got.row);
        check_field("cursor_col", want.col, got.col);
        check_field("cursor_location", want.loc, got.loc);
        check_field("cursor_update", want.upd, got.upd);
        check_field("scrolled", want.scr, got.scr);
        check_field("log_valid", want.lv, got.lv);
        check_field("log_byte", want.lb, got.lb);
        check_field("read_data", want.rd, got.rd);
      end
    end
  end

  // output side back-pressure
  initial begin : receiver
    int unsigned stall;
    stall = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_off = 1'b0;
      end else if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        stall = rx_calm ? 0 : gap_len();
      end
    end
  end

  task automatic send_word(logic [31:0] w, int unsigned gap, pinned_t pin);
    pinned_q.push_back(pin);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_regs(logic [7:0] attr_val, logic log_val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_SCROLL_ATTR;
    cfg_data_i  <= attr_val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    blank_attr = attr_val;
    @(negedge clk_i);
    cfg_index_i <= REG_LOG_EN;
    cfg_data_i  <= {7'd0, log_val};
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    log_on = log_val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(logic [7:0] attr_val, logic log_val, int n, bit calm_rx,
                           bit calm_tx, int hold_at, int pause_at);
    int unsigned r, gap;
    logic [1:0]  op;
    logic [7:0]  ch;
    logic [4:0]  rrow;
    logic [6:0]  rcol;
    int          i;
    wait_idle();
    set_regs(attr_val, log_val);
    rx_calm = calm_rx;
    tx_calm = calm_tx;
    for (i = 0; i < n; i++) begin
      r  = $urandom_range(99);
      op = (r < 72) ? OP_PUT : (r < 88) ? OP_READ : (r < 95) ? OP_FLUSH : OP_NOP;
      r  = $urandom_range(99);
      if (r < 62)      ch = 8'($urandom_range(255, 32));
      else if (r < 70) ch = CH_LF;
      else if (r < 78) ch = CH_TAB;
      else if (r < 85) ch = CH_BS;
      else if (r < 90) ch = CH_CR;
      else             ch = 8'($urandom_range(31));
      rrow = ($urandom_range(99) < 85) ? 5'($urandom_range(ROWS - 1)) : 5'($urandom);
      rcol = ($urandom_range(99) < 85) ? 7'($urandom_range(COLS - 1)) : 7'($urandom);
      if (i == hold_at) hold_off = 1'b1;
      gap = tx_calm ? 0 : gap_len();
      if ((i == pause_at || i == n - 1) && gap == 0) gap = 1;
      send_word({1'b0, rcol, rrow, 1'($urandom_range(3) == 0), 8'($urandom), ch, op},
                gap, '0);
      if (i == pause_at) wait_idle();
    end
  endtask

  initial begin : stimulus
    int unsigned k, j, gap, n;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_SCROLL_ATTR;
    cfg_data_i    = '0;
    rx_calm       = 1'b0;
    tx_calm       = 1'b0;
    hold_off      = 1'b0;
    mismatches    = 0;
    for (k = 0; k < ROWS * COLS; k++) cells[k] = RESET_CELL;
    top_row    = 0;
    cur_row    = 0;
    cur_col    = 0;
    blank_attr = SCROLL_ATTR_RST;
    log_on     = 1'b1;
    rst_ni     = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    n = $size(DIRECTED);
    for (k = 0; k < n; k++) begin
      for (j = 0; j < DIRECTED[k].rep; j++) begin
        gap = gap_len();
        if (k == n - 1 && j == DIRECTED[k].rep - 1 && gap == 0) gap = 1;
        send_word({1'b0, DIRECTED[k].rcol, DIRECTED[k].rrow, DIRECTED[k].defer,
                   DIRECTED[k].attr, DIRECTED[k].ch, DIRECTED[k].op},
                  gap, {DIRECTED[k].known, DIRECTED[k].res});
      end
    end

    run_phase(8'h00, 1'b0, PHASE_WORDS, 1'b0, 1'b0, -1, -1);
    run_phase(8'hff, 1'b1, PHASE_WORDS, 1'b1, 1'b0, -1, -1);
    run_phase(8'($urandom), 1'b1, PHASE_WORDS, 1'b0, 1'b0, 25, -1);
    run_phase(8'($urandom), 1'b0, PHASE_WORDS, 1'b0, 1'b0, -1, PHASE_WORDS / 2);
    run_phase(SCROLL_ATTR_RST, 1'b1, PHASE_WORDS, 1'b1, 1'b1, -1, -1);

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/tcce_pkg.sv
design/tcce_addr_unit.sv
design/tcce_cell_mem.sv
design/text_console_char_engine.sv
tb/text_console_char_engine_tb.sv
